### rtl/core/mcds_pkg.sv
// mcds_pkg: types, codes and constants shared by the dispense sequencer modules
// no dependencies
package mcds_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int MAX_DOSE_DEF = 16;
	localparam int MAX_OUTCOMES = 4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	localparam logic [1:0] ST_STARTED   = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_CANCELLED = 2'd2;
	localparam logic [1:0] ST_BUSY      = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WAIT    = 3'd1,
		PH_RELEASE = 3'd2,
		PH_RETURN  = 3'd3,
		PH_SHAKE   = 3'd4
	} phase_t;

	localparam logic [1:0] VM_OFF   = 2'd0;
	localparam logic [1:0] VM_KICK  = 2'd1;
	localparam logic [1:0] VM_RUN   = 2'd2;
	localparam logic [1:0] VM_BRAKE = 2'd3;

	localparam logic [2:0] REG_MOVE     = 3'd0;
	localparam logic [2:0] REG_SHAKE    = 3'd1;
	localparam logic [2:0] REG_STAGGER  = 3'd2;
	localparam logic [2:0] REG_KICK     = 3'd3;
	localparam logic [2:0] REG_LOCKOUT  = 3'd4;
	localparam logic [2:0] REG_ATTEMPTS = 3'd5;
	localparam logic [2:0] REG_CONCUR   = 3'd6;
	localparam logic [2:0] REG_SENSOR   = 3'd7;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] channel_number;
		logic [7:0] pill_target;
		logic [3:0] beam_blocked;
		logic       cancel_pressed;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] start_status;
		logic [3:0] done_channel;
		logic [7:0] asked_pills;
		logic [7:0] given_pills;
		logic [7:0] tries;
		logic       was_cancelled;
		logic       verified;
		logic [3:0] release_mask;
		logic [7:0] vibe_modes;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] move_time;
		logic [15:0] shake_time;
		logic [15:0] stagger_time;
		logic [15:0] kick_time;
		logic [15:0] lockout_time;
		logic [7:0]  max_attempts;
		logic [2:0]  max_concurrent;
		logic        sensor_enable;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture accepted input
		logic step;      // process the selected channel
		logic start;     // evaluate the start request
		logic emit_done; // load outcome of selected channel into output
		logic emit_rep;  // load start reply into output
		logic emit_stat; // load drive status into output
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       op_tick;
		logic       op_start;
		logic       op_stop;
		logic       cancel;
		logic       ch_done;   // selected channel finished on this step
		logic       any_done;  // room left for outcomes
	} dp_stat_t;

	function automatic logic [15:0] inc16(input logic [15:0] v);
		inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

### rtl/core/multi_channel_dispense_sequencer.sv
// multi_channel_dispense_sequencer: top level joining controller and datapath
// depends on mcds_pkg, mcds_ctrl, mcds_datapath
//
// usage: one input transaction per tick, start request or stop all on in_*.
// each input yields zero to four outcomes (or one start reply) followed by
// one drive status transaction with last set, on the out_* channel.
// config writes on cfg_* (index 0..7) are to be made only while idle; the block itself does not enforce this.
// a tick or stop walks the channels one per cycle while the output register
// is free, using the shared channel step unit; a start needs no walk.
// the next input is taken once the drive status has been handed over.
// a stalled receiver holds the output register; the walk pauses on an
// outcome until the register is free, and no result is lost.
// reset: all channels idle, registers at defaults (move 800, shake 500,
// stagger 300, kick 100, lockout 50, attempts 5, concurrency 2, sensor on).
module multi_channel_dispense_sequencer #(
	parameter int CHANNELS = mcds_pkg::CHANNELS_DEF,
	parameter int MAX_DOSE = mcds_pkg::MAX_DOSE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcds_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mcds_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	mcds_pkg::cfg_t cfg_q;
	mcds_pkg::dp_cmd_t cmd;
	mcds_pkg::dp_stat_t stat;
	logic [IW-1:0] sel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_time <= 16'd800;
			cfg_q.shake_time <= 16'd500;
			cfg_q.stagger_time <= 16'd300;
			cfg_q.kick_time <= 16'd100;
			cfg_q.lockout_time <= 16'd50;
			cfg_q.max_attempts <= 8'd5;
			cfg_q.max_concurrent <= 3'd2;
			cfg_q.sensor_enable <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				mcds_pkg::REG_MOVE:     cfg_q.move_time <= cfg_data;
				mcds_pkg::REG_SHAKE:    cfg_q.shake_time <= cfg_data;
				mcds_pkg::REG_STAGGER:  cfg_q.stagger_time <= cfg_data;
				mcds_pkg::REG_KICK:     cfg_q.kick_time <= cfg_data;
				mcds_pkg::REG_LOCKOUT:  cfg_q.lockout_time <= cfg_data;
				mcds_pkg::REG_ATTEMPTS: cfg_q.max_attempts <= cfg_data[7:0];
				mcds_pkg::REG_CONCUR:   cfg_q.max_concurrent <= cfg_data[2:0];
				mcds_pkg::REG_SENSOR:   cfg_q.sensor_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mcds_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd), .sel(sel)
	);

	mcds_datapath #(.CHANNELS(CHANNELS), .MAX_DOSE(MAX_DOSE)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg(cfg_q), .in_item(in_data),
		.cmd(cmd), .sel(sel), .stat(stat), .out_item(out_data)
	);

endmodule

### rtl/core/mcds_datapath.sv
// mcds_datapath: per-channel state registers, one shared channel step unit,
// start checks and output register; depends on mcds_pkg
module mcds_datapath #(
	parameter int CHANNELS = mcds_pkg::CHANNELS_DEF,
	parameter int MAX_DOSE = mcds_pkg::MAX_DOSE_DEF,
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcds_pkg::cfg_t      cfg,
	input  mcds_pkg::in_item_t  in_item,
	input  mcds_pkg::dp_cmd_t   cmd,
	input  logic [IW-1:0]       sel,
	output mcds_pkg::dp_stat_t  stat,
	output mcds_pkg::out_item_t out_item
);

	mcds_pkg::phase_t phase_q [CHANNELS];
	logic [7:0]  target_q [CHANNELS];
	logic [7:0]  pills_q [CHANNELS];
	logic [7:0]  attempts_q [CHANNELS];
	logic [15:0] pticks_q [CHANNELS];
	logic        reached_q [CHANNELS];
	logic        kicking_q [CHANNELS];
	logic [15:0] kticks_q [CHANNELS];
	logic        beam_q [CHANNELS];
	logic [15:0] since_q [CHANNELS];
	logic [15:0] delay_q [CHANNELS];
	mcds_pkg::in_item_t in_q;
	mcds_pkg::out_item_t out_q;
	mcds_pkg::out_item_t out_d;
	logic [2:0] nout_q;

	// single-channel step, evaluated for channel sel
	mcds_pkg::phase_t c_ph, n_ph;
	logic [7:0]  n_pills, n_att;
	logic [15:0] n_pt, n_kt, n_since, el;
	logic        n_reached, n_kick, n_beam, fin, fin_cancel, now_b, b_bit;
	logic [7:0]  att_inc;

	always_comb begin
		c_ph = phase_q[sel];
		n_ph = c_ph;
		n_pills = pills_q[sel];
		n_att = attempts_q[sel];
		n_pt = pticks_q[sel];
		n_kt = kticks_q[sel];
		n_since = since_q[sel];
		n_reached = reached_q[sel];
		n_kick = kicking_q[sel];
		n_beam = beam_q[sel];
		fin = 1'b0;
		fin_cancel = 1'b0;
		// only the first four channels have a beam input
		b_bit = 1'b0;
		for (int k = 0; k < CHANNELS && k < 4; k++)
			if (sel == IW'(k))
				b_bit = in_q.beam_blocked[k];
		now_b = b_bit;
		att_inc = (attempts_q[sel] == 8'hFF) ? attempts_q[sel] : attempts_q[sel] + 8'd1;
		el = 16'd0;
		if (c_ph != mcds_pkg::PH_IDLE) begin
			if (in_q.operation != mcds_pkg::OP_TICK || in_q.cancel_pressed) begin
				fin = 1'b1;
				fin_cancel = 1'b1;
				n_ph = mcds_pkg::PH_IDLE;
				n_kick = 1'b0;
			end else begin
				if (kicking_q[sel]) begin
					n_kt = mcds_pkg::inc16(kticks_q[sel]);
					if (n_kt >= cfg.kick_time)
						n_kick = 1'b0;
				end
				n_since = mcds_pkg::inc16(since_q[sel]);
				if (cfg.sensor_enable) begin
					n_beam = now_b;
					if (now_b && !beam_q[sel] && n_since >= cfg.lockout_time) begin
						n_since = 16'd0;
						if (n_pills != 8'hFF)
							n_pills = n_pills + 8'd1;
						if (n_pills >= target_q[sel])
							n_reached = 1'b1;
					end
				end
				el = mcds_pkg::inc16(pticks_q[sel]);
				n_pt = el;
				case (c_ph)
					mcds_pkg::PH_WAIT: begin
						if (el >= delay_q[sel]) begin
							n_ph = mcds_pkg::PH_RELEASE;
							n_att = att_inc;
							n_kick = 1'b1;
							n_kt = 16'd0;
							n_pt = 16'd0;
						end
					end
					mcds_pkg::PH_RELEASE: begin
						if (el >= cfg.move_time) begin
							n_ph = mcds_pkg::PH_RETURN;
							n_kick = 1'b0;
							n_pt = 16'd0;
						end
					end
					mcds_pkg::PH_RETURN: begin
						if (el >= cfg.move_time) begin
							if (n_reached || n_att >= cfg.max_attempts) begin
								fin = 1'b1;
								n_ph = mcds_pkg::PH_IDLE;
								n_kick = 1'b0;
							end else begin
								n_ph = mcds_pkg::PH_SHAKE;
								n_kick = 1'b1;
								n_kt = 16'd0;
								n_pt = 16'd0;
							end
						end
					end
					mcds_pkg::PH_SHAKE: begin
						if (el >= cfg.shake_time) begin
							if (n_reached) begin
								fin = 1'b1;
								n_ph = mcds_pkg::PH_IDLE;
								n_kick = 1'b0;
							end else begin
								n_ph = mcds_pkg::PH_RELEASE;
								n_att = att_inc;
								n_kick = 1'b1;
								n_kt = 16'd0;
								n_pt = 16'd0;
							end
						end
					end
					default: n_ph = mcds_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// start checks
	logic [3:0] running;
	logic [1:0] st_code;
	logic [IW-1:0] st_idx;
	logic [3:0] ch_m1;
	logic st_beam;
	always_comb begin
		running = 4'd0;
		for (int k = 0; k < CHANNELS; k++)
			if (phase_q[k] != mcds_pkg::PH_IDLE)
				running = running + 4'd1;
		ch_m1 = in_q.channel_number - 4'd1;
		st_idx = ch_m1[IW-1:0];
		st_beam = 1'b0;
		for (int k = 0; k < CHANNELS && k < 4; k++)
			if (st_idx == IW'(k))
				st_beam = in_q.beam_blocked[k];
		if (in_q.channel_number == 4'd0 || {28'd0, in_q.channel_number} > CHANNELS
			|| in_q.pill_target == 8'd0 || {24'd0, in_q.pill_target} > MAX_DOSE)
			st_code = mcds_pkg::ST_INVALID;
		else if (in_q.cancel_pressed)
			st_code = mcds_pkg::ST_CANCELLED;
		else if (phase_q[st_idx] != mcds_pkg::PH_IDLE)
			st_code = mcds_pkg::ST_BUSY;
		else if ({1'b0, running} >= {2'b0, cfg.max_concurrent})
			st_code = mcds_pkg::ST_BUSY;
		else
			st_code = mcds_pkg::ST_STARTED;
	end

	logic [3:0] rmask;
	logic [7:0] vmodes;
	always_comb begin
		rmask = 4'd0;
		vmodes = 8'd0;
		for (int k = 0; k < CHANNELS && k < 4; k++) begin
			case (phase_q[k])
				mcds_pkg::PH_RELEASE: begin
					rmask[k] = 1'b1;
					vmodes[2*k +: 2] = kicking_q[k] ? mcds_pkg::VM_KICK : mcds_pkg::VM_RUN;
				end
				mcds_pkg::PH_SHAKE:
					vmodes[2*k +: 2] = kicking_q[k] ? mcds_pkg::VM_KICK : mcds_pkg::VM_RUN;
				mcds_pkg::PH_RETURN: vmodes[2*k +: 2] = mcds_pkg::VM_BRAKE;
				default: vmodes[2*k +: 2] = mcds_pkg::VM_OFF;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				phase_q[k] <= mcds_pkg::PH_IDLE;
				target_q[k] <= 8'd0;
				pills_q[k] <= 8'd0;
				attempts_q[k] <= 8'd0;
				pticks_q[k] <= 16'd0;
				reached_q[k] <= 1'b0;
				kicking_q[k] <= 1'b0;
				kticks_q[k] <= 16'd0;
				beam_q[k] <= 1'b0;
				since_q[k] <= 16'hFFFF;
				delay_q[k] <= 16'd0;
			end
			nout_q <= 3'd0;
		end else begin
			if (cmd.load) begin
				nout_q <= 3'd0;
			end
			if (cmd.step) begin
				phase_q[sel] <= n_ph;
				pills_q[sel] <= n_pills;
				attempts_q[sel] <= n_att;
				pticks_q[sel] <= n_pt;
				reached_q[sel] <= n_reached;
				kicking_q[sel] <= n_kick;
				kticks_q[sel] <= n_kt;
				beam_q[sel] <= n_beam;
				since_q[sel] <= n_since;
			end
			if (cmd.start && st_code == mcds_pkg::ST_STARTED) begin
				target_q[st_idx] <= in_q.pill_target;
				pills_q[st_idx] <= 8'd0;
				reached_q[st_idx] <= 1'b0;
				since_q[st_idx] <= 16'hFFFF;
				if (cfg.sensor_enable)
					beam_q[st_idx] <= st_beam;
				pticks_q[st_idx] <= 16'd0;
				if (running == 4'd0) begin
					phase_q[st_idx] <= mcds_pkg::PH_RELEASE;
					attempts_q[st_idx] <= 8'd1;
					kicking_q[st_idx] <= 1'b1;
					kticks_q[st_idx] <= 16'd0;
				end else begin
					phase_q[st_idx] <= mcds_pkg::PH_WAIT;
					attempts_q[st_idx] <= 8'd0;
					delay_q[st_idx] <= cfg.stagger_time;
				end
			end
			if (cmd.emit_done)
				nout_q <= nout_q + 3'd1;
		end
	end

	always_comb begin
		out_d = '0;
		if (cmd.emit_done) begin
			out_d.kind = mcds_pkg::KIND_DONE;
			out_d.done_channel = 4'({1'b0, sel} + 1);
			out_d.asked_pills = target_q[sel];
			out_d.given_pills = cfg.sensor_enable ? n_pills :
				(fin_cancel ? 8'd0 : target_q[sel]);
			out_d.tries = n_att;
			out_d.was_cancelled = fin_cancel;
			out_d.verified = cfg.sensor_enable;
		end else if (cmd.emit_rep) begin
			out_d.kind = mcds_pkg::KIND_START;
			out_d.start_status = st_code;
		end else if (cmd.emit_stat) begin
			out_d.kind = mcds_pkg::KIND_STATUS;
			out_d.release_mask = rmask;
			out_d.vibe_modes = vmodes;
			out_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= in_item;
		if (cmd.emit_done || cmd.emit_rep || cmd.emit_stat)
			out_q <= out_d;
	end

	assign stat.op_tick  = (in_q.operation == mcds_pkg::OP_TICK);
	assign stat.op_start = (in_q.operation == mcds_pkg::OP_START);
	assign stat.op_stop  = (in_q.operation == mcds_pkg::OP_STOP);
	assign stat.cancel   = in_q.cancel_pressed;
	assign stat.ch_done  = fin;
	assign stat.any_done = (nout_q < 3'(mcds_pkg::MAX_OUTCOMES));
	assign out_item = out_q;

`ifndef ASSERT_OFF
	a_nout_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nout_q <= 3'(mcds_pkg::MAX_OUTCOMES)) else $error("outcome count overflow");
	a_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.emit_done, cmd.emit_rep, cmd.emit_stat}) <= 1)
		else $error("two output loads at once");
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_stat |=> out_q.last) else $error("status not marked last");
`endif

endmodule

### rtl/core/mcds_ctrl.sv
// mcds_ctrl: controller state machine walking the channels and sequencing
// output transactions; depends on mcds_pkg
module mcds_ctrl #(
	parameter int CHANNELS = mcds_pkg::CHANNELS_DEF,
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mcds_pkg::dp_stat_t stat,
	output mcds_pkg::dp_cmd_t  cmd,
	output logic [IW-1:0]      sel
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DISP  = 6'b000010,
		S_CHAN  = 6'b000100,
		S_WAITD = 6'b001000,
		S_STAT  = 6'b010000,
		S_WAITS = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [IW-1:0] sel_q, sel_d;
	logic out_valid_q, out_valid_d;
	logic last_ch;

	assign last_ch = ({{(32-IW){1'b0}}, sel_q} == CHANNELS - 1);

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		in_ready = 1'b0;
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				sel_d = '0;
				if (stat.op_start) begin
					if (!out_valid_q || out_ready) begin
						cmd.emit_rep = 1'b1;
						cmd.start = 1'b1;
						out_valid_d = 1'b1;
						state_d = S_STAT;
					end
				end else if (stat.op_tick || stat.op_stop)
					state_d = S_CHAN;
				else
					state_d = S_STAT;
			end
			S_CHAN: begin
				// an outcome needs the output register free before the step commits
				if (!stat.ch_done || !stat.any_done || !out_valid_q || out_ready) begin
					cmd.step = 1'b1;
					if (stat.ch_done && stat.any_done) begin
						cmd.emit_done = 1'b1;
						out_valid_d = 1'b1;
					end
					if (last_ch)
						state_d = S_STAT;
					else
						sel_d = sel_q + 1'b1;
				end
			end
			S_STAT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit_stat = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_WAITS;
				end
			end
			S_WAITS: begin
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			end
			S_WAITD: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign sel = sel_q;

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_done || cmd.emit_rep || cmd.emit_stat) |-> (!out_valid_q || out_ready))
		else $error("output overwritten");
`endif

endmodule

### tb/sv/mcds_checker.sv
// mcds_checker: watches the input, output and config channels of the dispense sequencer,
// predicts each input's results and compares them field by field
// depends on mcds_pkg
`timescale 1ns / 1ps

module mcds_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  mcds_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  mcds_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output int                  errors,
	output int                  pending
);

	localparam int NCH = mcds_pkg::CHANNELS_DEF;
	localparam int DOSE_MAX = mcds_pkg::MAX_DOSE_DEF;

	logic [15:0] move_t, shake_t, stagger_t, kick_t, lock_t;
	logic [7:0]  attempts_max;
	logic [2:0]  concur_max;
	logic        sensor_on;

	mcds_pkg::phase_t ph [NCH];
	logic [7:0]  target [NCH];
	logic [7:0]  pills [NCH];
	logic [7:0]  tries [NCH];
	logic [15:0] ph_ticks [NCH];
	logic        reached [NCH];
	logic        kicking [NCH];
	logic [15:0] kick_ticks [NCH];
	logic        beam_prev [NCH];
	logic [15:0] since_pill [NCH];
	logic [15:0] delay [NCH];

	mcds_pkg::out_item_t dose_results_q[$];
	int n_res;

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	task automatic reset_state();
		move_t = 16'd800; shake_t = 16'd500; stagger_t = 16'd300; kick_t = 16'd100;
		lock_t = 16'd50;
		attempts_max = 8'd5; concur_max = 3'd2; sensor_on = 1'b1;
		for (int i = 0; i < NCH; i++) begin
			ph[i] = mcds_pkg::PH_IDLE; target[i] = 8'd0; pills[i] = 8'd0; tries[i] = 8'd0;
			ph_ticks[i] = 16'd0; reached[i] = 1'b0; kicking[i] = 1'b0; kick_ticks[i] = 16'd0;
			beam_prev[i] = 1'b0; since_pill[i] = 16'hFFFF; delay[i] = 16'd0;
		end
	endtask

	task automatic push_result(mcds_pkg::out_item_t r);
		dose_results_q.push_back(r);
		n_res++;
	endtask

	task automatic end_run(int i, logic cancelled);
		mcds_pkg::out_item_t r;
		if (ph[i] == mcds_pkg::PH_IDLE)
			return;
		kicking[i] = 1'b0;
		ph[i] = mcds_pkg::PH_IDLE;
		if (n_res >= mcds_pkg::MAX_OUTCOMES)
			return;
		r = '0;
		r.kind = mcds_pkg::KIND_DONE;
		r.done_channel = 4'(i + 1);
		r.asked_pills = target[i];
		r.given_pills = sensor_on ? pills[i] : (cancelled ? 8'd0 : target[i]);
		r.tries = tries[i];
		r.was_cancelled = cancelled;
		r.verified = sensor_on;
		push_result(r);
	endtask

	task automatic enter_phase(int i, mcds_pkg::phase_t nx);
		if (nx == mcds_pkg::PH_RELEASE) begin
			if (tries[i] != 8'd255)
				tries[i]++;
			kicking[i] = 1'b1;
			kick_ticks[i] = 16'd0;
		end else if (nx == mcds_pkg::PH_RETURN) begin
			kicking[i] = 1'b0;
		end else if (nx == mcds_pkg::PH_SHAKE) begin
			kicking[i] = 1'b1;
			kick_ticks[i] = 16'd0;
		end
		ph[i] = nx;
		ph_ticks[i] = 16'd0;
	endtask

	task automatic advance_channel(int i, logic [3:0] beams);
		logic now_b;
		if (ph[i] == mcds_pkg::PH_IDLE)
			return;
		if (kicking[i]) begin
			kick_ticks[i] = sat_inc(kick_ticks[i]);
			if (kick_ticks[i] >= kick_t)
				kicking[i] = 1'b0;
		end
		since_pill[i] = sat_inc(since_pill[i]);
		if (sensor_on) begin
			now_b = (i < 4) ? beams[i] : 1'b0;
			// rising edge outside the lockout window counts one pill
			if (now_b && !beam_prev[i] && since_pill[i] >= lock_t) begin
				since_pill[i] = 16'd0;
				if (pills[i] != 8'd255)
					pills[i]++;
				if (pills[i] >= target[i])
					reached[i] = 1'b1;
			end
			beam_prev[i] = now_b;
		end
		ph_ticks[i] = sat_inc(ph_ticks[i]);
		case (ph[i])
			mcds_pkg::PH_WAIT: begin
				if (ph_ticks[i] >= delay[i])
					enter_phase(i, mcds_pkg::PH_RELEASE);
			end
			mcds_pkg::PH_RELEASE: begin
				if (ph_ticks[i] >= move_t)
					enter_phase(i, mcds_pkg::PH_RETURN);
			end
			mcds_pkg::PH_RETURN: begin
				if (ph_ticks[i] >= move_t) begin
					if (reached[i] || tries[i] >= attempts_max)
						end_run(i, 1'b0);
					else
						enter_phase(i, mcds_pkg::PH_SHAKE);
				end
			end
			mcds_pkg::PH_SHAKE: begin
				if (ph_ticks[i] >= shake_t) begin
					if (reached[i])
						end_run(i, 1'b0);
					else
						enter_phase(i, mcds_pkg::PH_RELEASE);
				end
			end
			default: ph[i] = mcds_pkg::PH_IDLE;
		endcase
	endtask

	task automatic start_dose(mcds_pkg::in_item_t it, output logic [1:0] st);
		int i;
		int running;
		running = 0;
		if (it.channel_number < 1 || it.channel_number > NCH ||
				it.pill_target < 1 || it.pill_target > DOSE_MAX) begin
			st = mcds_pkg::ST_INVALID;
			return;
		end
		if (it.cancel_pressed) begin
			st = mcds_pkg::ST_CANCELLED;
			return;
		end
		i = it.channel_number - 1;
		for (int k = 0; k < NCH; k++)
			if (ph[k] != mcds_pkg::PH_IDLE)
				running++;
		if (ph[i] != mcds_pkg::PH_IDLE || running >= concur_max) begin
			st = mcds_pkg::ST_BUSY;
			return;
		end
		target[i] = it.pill_target;
		pills[i] = 8'd0;
		tries[i] = 8'd0;
		reached[i] = 1'b0;
		since_pill[i] = 16'hFFFF;
		if (sensor_on)
			beam_prev[i] = (i < 4) ? it.beam_blocked[i] : 1'b0;
		if (running == 0) begin
			enter_phase(i, mcds_pkg::PH_RELEASE);
		end else begin
			delay[i] = stagger_t;
			enter_phase(i, mcds_pkg::PH_WAIT);
		end
		st = mcds_pkg::ST_STARTED;
	endtask

	task automatic predict_dose_results(mcds_pkg::in_item_t it);
		mcds_pkg::out_item_t r;
		logic [1:0] st;
		logic [1:0] m;
		n_res = 0;
		case (mcds_pkg::op_t'(it.operation))
			mcds_pkg::OP_TICK: begin
				for (int i = 0; i < NCH; i++)
					if (it.cancel_pressed)
						end_run(i, 1'b1);
					else
						advance_channel(i, it.beam_blocked);
			end
			mcds_pkg::OP_START: begin
				start_dose(it, st);
				r = '0;
				r.kind = mcds_pkg::KIND_START;
				r.start_status = st;
				push_result(r);
			end
			mcds_pkg::OP_STOP: begin
				for (int i = 0; i < NCH; i++)
					end_run(i, 1'b1);
			end
			default: ;
		endcase
		r = '0;
		r.kind = mcds_pkg::KIND_STATUS;
		r.last = 1'b1;
		for (int i = 0; i < NCH && i < 4; i++) begin
			m = mcds_pkg::VM_OFF;
			if (ph[i] == mcds_pkg::PH_RELEASE) begin
				r.release_mask[i] = 1'b1;
				m = kicking[i] ? mcds_pkg::VM_KICK : mcds_pkg::VM_RUN;
			end else if (ph[i] == mcds_pkg::PH_SHAKE) begin
				m = kicking[i] ? mcds_pkg::VM_KICK : mcds_pkg::VM_RUN;
			end else if (ph[i] == mcds_pkg::PH_RETURN) begin
				m = mcds_pkg::VM_BRAKE;
			end
			r.vibe_modes[2*i +: 2] = m;
		end
		push_result(r);
	endtask

	task automatic check_field(string nm, logic [7:0] e, logic [7:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", nm, e, a);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mcds_pkg::out_item_t e;
		if (!arst_n) begin
			reset_state();
			dose_results_q.delete();
			errors = 0;
		end else begin
			// results first, so a transaction never meets its own input's prediction
			if (out_valid && out_ready) begin
				if (dose_results_q.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					e = dose_results_q.pop_front();
					check_field("kind", e.kind, out_data.kind);
					check_field("start_status", e.start_status, out_data.start_status);
					check_field("done_channel", e.done_channel, out_data.done_channel);
					check_field("asked_pills", e.asked_pills, out_data.asked_pills);
					check_field("given_pills", e.given_pills, out_data.given_pills);
					check_field("tries", e.tries, out_data.tries);
					check_field("was_cancelled", e.was_cancelled, out_data.was_cancelled);
					check_field("verified", e.verified, out_data.verified);
					check_field("release_mask", e.release_mask, out_data.release_mask);
					check_field("vibe_modes", e.vibe_modes, out_data.vibe_modes);
					check_field("last", e.last, out_data.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mcds_pkg::REG_MOVE:     move_t = cfg_data;
					mcds_pkg::REG_SHAKE:    shake_t = cfg_data;
					mcds_pkg::REG_STAGGER:  stagger_t = cfg_data;
					mcds_pkg::REG_KICK:     kick_t = cfg_data;
					mcds_pkg::REG_LOCKOUT:  lock_t = cfg_data;
					mcds_pkg::REG_ATTEMPTS: attempts_max = cfg_data[7:0];
					mcds_pkg::REG_CONCUR:   concur_max = cfg_data[2:0];
					mcds_pkg::REG_SENSOR:   sensor_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_dose_results(in_data);
		end
		pending = dose_results_q.size();
	end

endmodule

### tb/sv/tb_multi_channel_dispense_sequencer.sv
// tb_multi_channel_dispense_sequencer: stimulus and verdict for the dispense sequencer
// depends on mcds_pkg, multi_channel_dispense_sequencer and mcds_checker
`timescale 1ns / 1ps

module tb_multi_channel_dispense_sequencer;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE = 20;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	mcds_pkg::in_item_t in_data;
	mcds_pkg::out_item_t out_data;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	int errors, pending;
	int idle_cycles;
	bit calm;
	bit hold_req;

	multi_channel_dispense_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mcds_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("multi_channel_dispense_sequencer: mismatch");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = calm ? 0 : $urandom_range(0, 4);
			if (hold_req) begin
				n = 300;
				hold_req = 0;
			end
			if (n > 0) begin
				out_ready <= 0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	task automatic send_item(mcds_pkg::in_item_t it);
		int n;
		n = calm ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_op(mcds_pkg::op_t op, int ch, int tgt, int beams, bit cancel);
		mcds_pkg::in_item_t it;
		it.operation = op;
		it.channel_number = 4'(ch);
		it.pill_target = 8'(tgt);
		it.beam_blocked = 4'(beams);
		it.cancel_pressed = cancel;
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apply_settings(logic [15:0] v [8]);
		wait_drained();
		for (int idx = 0; idx < 8; idx++) begin
			cfg_valid <= 1;
			cfg_index <= 3'(idx);
			cfg_data <= v[idx];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 0;
	endtask

	function automatic mcds_pkg::in_item_t random_item();
		mcds_pkg::in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.beam_blocked = 4'($urandom_range(0, 15));
		it.cancel_pressed = ($urandom_range(0, 19) == 0);
		it.channel_number = 4'($urandom_range(1, 4));
		it.pill_target = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 16))
			: 8'($urandom_range(1, 3));
		if (r < 68) begin
			it.operation = mcds_pkg::OP_TICK;
		end else if (r < 88) begin
			it.operation = mcds_pkg::OP_START;
			it.cancel_pressed = ($urandom_range(0, 15) == 0);
		end else if (r < 93) begin
			// start with any channel and target, mostly malformed
			it.operation = mcds_pkg::OP_START;
			it.channel_number = 4'($urandom_range(0, 15));
			it.pill_target = 8'($urandom_range(0, 255));
		end else if (r < 97) begin
			it.operation = mcds_pkg::OP_STOP;
		end else begin
			it.operation = mcds_pkg::OP_NOP;
		end
		return it;
	endfunction

	initial begin
		logic [15:0] v [8];
		int n_items;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		hold_req = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// start checks, ticks and stops at reset settings
		send_op(mcds_pkg::OP_START, 0, 1, 0, 0);
		send_op(mcds_pkg::OP_START, 5, 1, 0, 0);
		send_op(mcds_pkg::OP_START, 15, 255, 15, 1);
		send_op(mcds_pkg::OP_START, 1, 0, 0, 0);
		send_op(mcds_pkg::OP_START, 1, 17, 0, 0);
		send_op(mcds_pkg::OP_START, 1, 3, 0, 1);
		send_op(mcds_pkg::OP_NOP, 0, 0, 0, 0);
		send_op(mcds_pkg::OP_START, 1, 16, 1, 0);
		send_op(mcds_pkg::OP_START, 1, 2, 0, 0);
		send_op(mcds_pkg::OP_START, 2, 1, 0, 0);
		send_op(mcds_pkg::OP_START, 3, 1, 0, 0);
		send_op(mcds_pkg::OP_TICK, 0, 0, 15, 0);
		send_op(mcds_pkg::OP_TICK, 0, 0, 0, 0);
		send_op(mcds_pkg::OP_TICK, 0, 0, 0, 1);
		send_op(mcds_pkg::OP_STOP, 0, 0, 0, 0);
		send_op(mcds_pkg::OP_START, 4, 16, 8, 0);
		send_op(mcds_pkg::OP_TICK, 0, 0, 8, 0);
		send_op(mcds_pkg::OP_STOP, 0, 0, 0, 0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: v = '{16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 16'd255, 16'd4, 16'd1};
				1: v = '{16'd1, 16'd3, 16'd3, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd0};
				2: v = '{16'd3, 16'd2, 16'd2, 16'd1, 16'd2, 16'd3, 16'd3, 16'd1};
				3: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'd1, 16'd2, 16'd2, 16'd1};
				4: v = '{16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
					16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
					16'($urandom_range(0, 3)), 16'($urandom_range(1, 6)),
					16'($urandom_range(1, 4)), 16'($urandom_range(0, 1))};
				default: v = '{16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd255, 16'd4, 16'd0};
			endcase
			apply_settings(v);
			calm = (p == 5);
			if (p == 2)
				hold_req = 1;
			n_items = (p == 3) ? 25 : 37;
			for (int k = 0; k < n_items; k++) begin
				if (p == 4 && k == 18) begin
					in_valid <= 0;
					while (pending != 0) @(negedge clk);
				end
				send_item(random_item());
			end
		end

		wait_drained();
		if (errors == 0)
			$display("multi_channel_dispense_sequencer: match");
		else
			$display("multi_channel_dispense_sequencer: mismatch");
		$finish;
	end

endmodule
